// ===== rtl/dqr_pkg.sv =====
// ----------------------------------------------------------------------------
// dqr_pkg
// Shared types and constants of the deque with indexed removal.
// ----------------------------------------------------------------------------
`default_nettype none

package dqr_pkg;

    // word field widths
    localparam int DATA_W    = 32;
    localparam int TYPE_W    = 2;
    localparam int POS_W     = 6;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 7;

    // defaults of the top level parameters
    localparam int ELEM_BITS_DEF = 32;
    localparam int DEPTH_DEF     = 64;

    // index width that covers the largest supported depth including the count
    localparam int MAX_CNT_W = 11;

    typedef enum logic [TYPE_W-1:0] {
        REQ_PUSH_TAIL = 2'd0,
        REQ_POP_HEAD  = 2'd1,
        REQ_POP_TAIL  = 2'd2,
        REQ_REMOVE_AT = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic                 push;
        logic                 remove;
        logic [MAX_CNT_W-1:0] wr_idx;
        logic [MAX_CNT_W-1:0] sel_idx;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/dqr_req_if.sv =====
// ----------------------------------------------------------------------------
// dqr_req_if
// Request channel: valid/ready handshake with request type, data and position.
// ----------------------------------------------------------------------------
`default_nettype none

interface dqr_req_if;
    import dqr_pkg::*;

    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] req_type;
    logic [DATA_W-1:0] push_data;
    logic [POS_W-1:0]  position;

    modport source (output valid, output req_type, output push_data, output position,
                    input ready);
    modport sink   (input valid, input req_type, input push_data, input position,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/dqr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dqr_rsp_if
// Response channel: valid/ready handshake with removed data, status and count.
// ----------------------------------------------------------------------------
`default_nettype none

interface dqr_rsp_if;
    import dqr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_W-1:0]    out_data;
    logic [STAT_W-1:0]    status;
    logic [CNT_OUT_W-1:0] count;

    modport source (output valid, output out_data, output status, output count,
                    input ready);
    modport sink   (input valid, input out_data, input status, input count,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/dqr_cell.sv =====
// ----------------------------------------------------------------------------
// dqr_cell
// One storage slot of the chain: loads a pushed element at its own index or
// takes its right neighbor's element when a removal closes the gap.
// ----------------------------------------------------------------------------
`default_nettype none

module dqr_cell #(
    parameter int ELEM_BITS = dqr_pkg::ELEM_BITS_DEF,
    parameter int IDX       = 0
) (
    input  wire logic                   i_clk,
    input  wire dqr_pkg::t_cell_ctl     i_ctl,
    input  wire logic [ELEM_BITS-1:0]   i_push_data,
    input  wire logic [ELEM_BITS-1:0]   i_next_data,
    output logic      [ELEM_BITS-1:0]   o_data,
    output logic      [ELEM_BITS-1:0]   o_tap
);
    import dqr_pkg::*;

    localparam logic [MAX_CNT_W-1:0] MY_IDX = MAX_CNT_W'(IDX);

    logic [ELEM_BITS-1:0] r_data;
    logic [ELEM_BITS-1:0] n_data;
    logic                 hit_sel;

    assign hit_sel = (i_ctl.sel_idx == MY_IDX);

    always_comb begin
        n_data = r_data;
        if (i_ctl.push && (i_ctl.wr_idx == MY_IDX)) begin
            n_data = i_push_data;
        end else if (i_ctl.remove && (MY_IDX >= i_ctl.sel_idx)) begin
            n_data = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // only the selected slot drives the removal tap
    assign o_tap  = hit_sel ? r_data : '0;

endmodule

`default_nettype wire

// ===== rtl/deque_with_indexed_removal_core.sv =====
// ----------------------------------------------------------------------------
// deque_with_indexed_removal_core
// Bounded ordered store with push tail, pop head, pop tail and remove at
// position, built as a row of shifting storage cells.
//
// Usage:
//   Requests enter on i_req (valid/ready); each request gives exactly one
//   response word on o_rsp carrying the removed element (zero for a push or
//   a failed request), a status and the element count after the request.
//   Every cell updates in the same cycle: a push loads the cell at the count,
//   a removal shifts all cells at or above the selected index one place
//   toward the head. The removed element is picked from the cell taps.
//   The response is valid in the cycle after accept; one request per cycle
//   is taken if not stalled, set by the single cell update and count register.
//   The response sits in an output register; while it is not taken a new
//   request is accepted only in the cycle the response leaves, so a stalled
//   receiver holds the request side too. Failing requests (full, empty,
//   position out of range) leave the store unchanged.
//   Reset clears the count and the response valid; cell contents are not
//   cleared, only slots below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_indexed_removal_core #(
    parameter int ELEM_BITS = dqr_pkg::ELEM_BITS_DEF,
    parameter int DEPTH     = dqr_pkg::DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dqr_req_if.sink   i_req,
    dqr_rsp_if.source o_rsp
);
    import dqr_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_data;
    logic [STAT_W-1:0]    r_out_status;
    logic [CNT_OUT_W-1:0] r_out_count;

    logic                 accept;
    logic                 do_push;
    logic                 do_remove;
    t_status              status;
    logic [CNT_W-1:0]     sel_idx;
    t_cell_ctl            ctl;
    logic [ELEM_BITS-1:0] push_elem;
    logic [ELEM_BITS-1:0] tap_or;
    logic [DATA_W-1:0]    removed;

    logic [ELEM_BITS-1:0] cell_data [DEPTH];
    logic [ELEM_BITS-1:0] cell_tap  [DEPTH];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    // request decode
    always_comb begin
        do_push   = 1'b0;
        do_remove = 1'b0;
        status    = ST_OK;
        sel_idx   = '0;
        case (i_req.req_type)
            REQ_PUSH_TAIL: begin
                if (r_count == FULL_CNT) begin
                    status = ST_FULL;
                end else begin
                    do_push = 1'b1;
                end
            end
            REQ_POP_HEAD: begin
                sel_idx = '0;
            end
            REQ_POP_TAIL: begin
                sel_idx = r_count - CNT_W'(1);
            end
            REQ_REMOVE_AT: begin
                sel_idx = CNT_W'(i_req.position);
            end
            default: begin
                sel_idx = '0;
            end
        endcase
        if (i_req.req_type != REQ_PUSH_TAIL) begin
            if (r_count == '0) begin
                status = ST_EMPTY;
            end else if ((i_req.req_type == REQ_REMOVE_AT)
                         && (CMP_W'(i_req.position) >= CMP_W'(r_count))) begin
                status = ST_RANGE;
            end else begin
                do_remove = 1'b1;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (do_push) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_remove) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign ctl.push    = accept && do_push;
    assign ctl.remove  = accept && do_remove;
    assign ctl.wr_idx  = MAX_CNT_W'(r_count);
    assign ctl.sel_idx = MAX_CNT_W'(sel_idx);

    generate
        if (ELEM_BITS >= DATA_W) begin : g_push_wide
            assign push_elem = ELEM_BITS'(i_req.push_data);
        end else begin : g_push_narrow
            assign push_elem = i_req.push_data[ELEM_BITS-1:0];
        end
    endgenerate

    generate
        for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [ELEM_BITS-1:0] next_data;
            if (gi < DEPTH - 1) begin : g_mid
                assign next_data = cell_data[gi+1];
            end else begin : g_last
                assign next_data = cell_data[gi];
            end
            dqr_cell #(
                .ELEM_BITS (ELEM_BITS),
                .IDX       (gi)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_push_data (push_elem),
                .i_next_data (next_data),
                .o_data      (cell_data[gi]),
                .o_tap       (cell_tap[gi])
            );
        end
    endgenerate

    always_comb begin
        tap_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            tap_or = tap_or | cell_tap[k];
        end
    end

    generate
        if (ELEM_BITS > DATA_W) begin : g_out_wide
            assign removed = tap_or[DATA_W-1:0];
        end else begin : g_out_narrow
            assign removed = DATA_W'(tap_or);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data   <= do_remove ? removed : '0;
            r_out_status <= status;
            r_out_count  <= CNT_OUT_W'(n_count);
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.out_data = r_out_data;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.count    = r_out_count;

endmodule

`default_nettype wire

// ===== tb/tb_deque_with_indexed_removal_core.sv =====
// ----------------------------------------------------------------------------
// tb_deque_with_indexed_removal_core
// Self-checking bench for the deque with indexed removal. A mirror of the
// store predicts each response word from the accepted requests; a response
// monitor compares every word field by field. Directed corner requests come
// first, then phases of random requests with varied push bias, a fill to
// full, a long receiver hold-off and a drain pause, and a final part with
// no idling on either side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_deque_with_indexed_removal_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dqr_pkg::*;

    localparam int DEPTH         = DEPTH_DEF;
    localparam int LONG_HOLD_CYC = 400;

    typedef struct packed {
        logic [DATA_W-1:0]    out_data;
        t_status              status;
        logic [CNT_OUT_W-1:0] count;
    } t_rsp_word;

    // mirror of the store plus the response words it still owes
    class deque_mirror;
        logic [DATA_W-1:0] cells[$];
        t_rsp_word         owed_rsp[$];
        int                errors;

        function new();
            errors = 0;
        endfunction

        function void note_request(t_req rt, logic [DATA_W-1:0] d, logic [POS_W-1:0] p);
            t_rsp_word w;
            w.out_data = '0;
            w.status   = ST_OK;
            if (rt == REQ_PUSH_TAIL) begin
                if (cells.size() >= DEPTH) begin
                    w.status = ST_FULL;
                end else begin
                    cells.push_back(d);
                end
            end else if (cells.size() == 0) begin
                // empty wins over the position check
                w.status = ST_EMPTY;
            end else if (rt == REQ_POP_HEAD) begin
                w.out_data = cells.pop_front();
            end else if (rt == REQ_POP_TAIL) begin
                w.out_data = cells.pop_back();
            end else if (int'(p) >= cells.size()) begin
                w.status = ST_RANGE;
            end else begin
                w.out_data = cells[p];
                cells.delete(int'(p));
            end
            w.count = CNT_OUT_W'(cells.size());
            owed_rsp.push_back(w);
        endfunction

        function void fail_note(string what, logic [DATA_W-1:0] exp_v,
                                logic [DATA_W-1:0] act_v);
            errors++;
            $display("%0t mismatch %s: expected %0h actual %0h", $time, what, exp_v, act_v);
        endfunction

        function void check_response(logic [DATA_W-1:0] d, logic [STAT_W-1:0] st,
                                     logic [CNT_OUT_W-1:0] c);
            t_rsp_word w;
            if (owed_rsp.size() == 0) begin
                errors++;
                $display("%0t unexpected response word: data %0h status %0d count %0d",
                         $time, d, st, c);
                return;
            end
            w = owed_rsp.pop_front();
            if (d !== w.out_data)
                fail_note("out_data", w.out_data, d);
            if (st !== w.status)
                fail_note("status", DATA_W'(w.status), DATA_W'(st));
            if (c !== w.count)
                fail_note("count", DATA_W'(w.count), DATA_W'(c));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    dqr_req_if req_if ();
    dqr_rsp_if rsp_if ();

    deque_with_indexed_removal_core #(
        .ELEM_BITS(ELEM_BITS_DEF),
        .DEPTH    (DEPTH)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    deque_mirror mirror = new();

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit long_hold  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

    // response side: random stall bursts, one long hold-off on request
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYC) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            mirror.check_response(rsp_if.out_data, rsp_if.status, rsp_if.count);
    end

    // offer one request word and hold it until taken
    task automatic send_word(t_req rt, logic [DATA_W-1:0] d, logic [POS_W-1:0] p);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= rt;
        req_if.push_data <= d;
        req_if.position  <= p;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        mirror.note_request(rt, d, p);
    endtask

    task automatic send_random(int push_pct);
        t_req              rt;
        logic [DATA_W-1:0] d;
        logic [POS_W-1:0]  p;
        int                cnt;
        cnt = mirror.cells.size();
        if ($urandom_range(0, 99) < push_pct) begin
            rt = REQ_PUSH_TAIL;
        end else begin
            case ($urandom_range(0, 2))
                0:       rt = REQ_POP_HEAD;
                1:       rt = REQ_POP_TAIL;
                default: rt = REQ_REMOVE_AT;
            endcase
        end
        case ($urandom_range(0, 7))
            0:       d = '0;
            1:       d = '1;
            default: d = $urandom();
        endcase
        // mostly in range positions, some anywhere in the field
        if (cnt > 0 && $urandom_range(0, 3) != 0)
            p = POS_W'($urandom_range(0, cnt - 1));
        else
            p = POS_W'($urandom_range(0, 63));
        send_word(rt, d, p);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (mirror.owed_rsp.size() != 0) @(posedge i_clk);
    endtask

    task automatic fill_and_poke();
        while (mirror.cells.size() < DEPTH)
            send_word(REQ_PUSH_TAIL, $urandom(), POS_W'($urandom_range(0, 63)));
        send_word(REQ_PUSH_TAIL, 32'hFFFF_FFFF, 6'd0);
        send_word(REQ_PUSH_TAIL, 32'h0000_0000, 6'd63);
        send_word(REQ_REMOVE_AT, 32'h0, 6'd63);
        send_word(REQ_REMOVE_AT, 32'hFFFF_FFFF, 6'd62);
        send_word(REQ_PUSH_TAIL, $urandom(), 6'd0);
        send_word(REQ_PUSH_TAIL, $urandom(), 6'd0);
        send_word(REQ_REMOVE_AT, 32'h0, 6'd0);
    endtask

    initial begin
        int pct;
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.req_type  <= REQ_PUSH_TAIL;
        req_if.push_data <= '0;
        req_if.position  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store, including a position that would be out of range
        send_word(REQ_POP_HEAD,  32'h0, 6'd0);
        send_word(REQ_POP_TAIL,  32'hFFFF_FFFF, 6'd63);
        send_word(REQ_REMOVE_AT, 32'h0, 6'd0);
        send_word(REQ_REMOVE_AT, 32'h0, 6'd63);
        send_word(REQ_PUSH_TAIL, 32'h0000_0000, 6'd0);
        send_word(REQ_PUSH_TAIL, 32'hFFFF_FFFF, 6'd63);
        send_word(REQ_PUSH_TAIL, 32'hAAAA_AAAA, 6'd21);
        send_word(REQ_PUSH_TAIL, 32'h5555_5555, 6'd42);
        send_word(REQ_PUSH_TAIL, 32'h1234_5678, 6'd0);
        // position equal to count and far above it
        send_word(REQ_REMOVE_AT, 32'h0, 6'd5);
        send_word(REQ_REMOVE_AT, 32'h0, 6'd63);
        send_word(REQ_REMOVE_AT, 32'h0, 6'd2);
        send_word(REQ_REMOVE_AT, 32'h0, 6'd3);
        send_word(REQ_REMOVE_AT, 32'h0, 6'd0);
        send_word(REQ_POP_TAIL,  32'hFFFF_FFFF, 6'd63);
        send_word(REQ_POP_HEAD,  32'hFFFF_FFFF, 6'd63);
        send_word(REQ_PUSH_TAIL, 32'hDEAD_BEEF, 6'd63);
        send_word(REQ_POP_TAIL,  32'h0, 6'd0);
        send_word(REQ_POP_HEAD,  32'h0, 6'd0);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case ($urandom_range(0, 3))
                0:       pct = 20;
                1:       pct = 50;
                2:       pct = 70;
                default: pct = 90;
            endcase
            repeat (100) send_random(pct);
        end

        fill_and_poke();

        // receiver holds off long while requests keep coming
        long_hold = 1'b1;
        repeat (30) send_random(60);
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            pct = $urandom_range(15, 95);
            repeat (100) send_random(pct);
        end

        // last part runs at full rate
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        fill_and_poke();
        repeat (120) send_random(45);
        repeat (120) send_random(75);
        req_if.valid <= 1'b0;

        @(posedge i_clk);
        while (mirror.owed_rsp.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.owed_rsp.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/dqr_pkg.sv
rtl/dqr_req_if.sv
rtl/dqr_rsp_if.sv
rtl/dqr_cell.sv
rtl/deque_with_indexed_removal_core.sv
tb/tb_deque_with_indexed_removal_core.sv
